>>> rtl/stu_pkg.sv
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types, token kinds, error codes and the keyword table of the
// script tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stu_pkg;

  localparam int TokenBuf     = 128;
  localparam int KwChars      = 12;
  localparam int NumKw        = 23;
  localparam int MaxRes       = 3;
  localparam int LineW        = 20;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrW    = $clog2(QueueDepth);

  localparam logic [LineW-1:0] LineMax = {LineW{1'b1}};

  // token kinds
  localparam logic [5:0] KindEof     = 6'd0;
  localparam logic [5:0] KindNewline = 6'd1;
  localparam logic [5:0] KindBang    = 6'd2;
  localparam logic [5:0] KindLParen  = 6'd3;
  localparam logic [5:0] KindRParen  = 6'd4;
  localparam logic [5:0] KindLBrace  = 6'd5;
  localparam logic [5:0] KindRBrace  = 6'd6;
  localparam logic [5:0] KindStrEnd  = 6'd7;
  localparam logic [5:0] KindKw0     = 6'd8;
  localparam logic [5:0] KindChar    = 6'd31;
  localparam logic [5:0] KindErr     = 6'd32;

  // error codes
  localparam logic [7:0] ErrUnknownWord = 8'd0;
  localparam logic [7:0] ErrWordLong    = 8'd1;
  localparam logic [7:0] ErrBadEscape   = 8'd2;
  localparam logic [7:0] ErrEscAtEol    = 8'd3;
  localparam logic [7:0] ErrStrLong     = 8'd4;
  localparam logic [7:0] ErrNoQuote     = 8'd5;

  // characters
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChBang      = 8'h21;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChComma     = 8'h2c;
  localparam logic [7:0] ChSemi      = 8'h3b;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLBrace    = 8'h7b;
  localparam logic [7:0] ChRBrace    = 8'h7d;

  // keywords, right-justified and zero-padded, same layout as the word shifter
  localparam logic [KwChars*8-1:0] KwText [NumKw] = '{
    (KwChars*8)'("cell"),     (KwChars*8)'("checkbox"), (KwChars*8)'("else"),
    (KwChars*8)'("find"),     (KwChars*8)'("form"),     (KwChars*8)'("if"),
    (KwChars*8)'("inner"),    (KwChars*8)'("input"),    (KwChars*8)'("load"),
    (KwChars*8)'("next"),     (KwChars*8)'("outer"),    (KwChars*8)'("page"),
    (KwChars*8)'("password"), (KwChars*8)'("prev"),     (KwChars*8)'("print"),
    (KwChars*8)'("radiobutton"), (KwChars*8)'("row"),   (KwChars*8)'("select"),
    (KwChars*8)'("string"),   (KwChars*8)'("submit"),   (KwChars*8)'("table"),
    (KwChars*8)'("textbox"),  (KwChars*8)'("textarea")
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } stu_in_t;

  typedef struct packed {
    logic [5:0]       kind;
    logic [7:0]       value;
    logic [LineW-1:0] line_number;
    logic             last;
  } stu_out_t;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] value;
  } stu_res_t;

  // all results caused by one input item
  typedef struct packed {
    logic [1:0]              cnt;
    logic [LineW-1:0]        line;
    stu_res_t [MaxRes-1:0]   res;
  } stu_entry_t;

  // escape decode: {hit, decoded char}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h6e:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      ChQuote: r = {1'b1, 8'd34};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/stu_front.sv
// ----------------------------------------------------------------------------
// stu_front
// Lexer state machine: takes one character per cycle unless the queue is full,
// classifies it and pushes the group of tokens it causes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_front
  import stu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire stu_in_t    in_data_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output stu_entry_t      q_data_o
);

  typedef enum logic [2:0] {
    ModeIdle, ModeWord, ModeStr, ModeStrEsc, ModeComment, ModeSkip, ModeSkipEsc
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [KwChars*8-1:0]  wvec_q, wvec_d;
  logic [7:0]            wlen_q, wlen_d;
  logic [7:0]            slen_q, slen_d;
  logic [LineW-1:0]      line_q, line_d;

  logic [7:0]       c;
  logic             accept;
  logic [LineW-1:0] cur_line;

  // idle-state character decode
  logic       ic_has, ic_line_inc, ic_word, ic_str;
  logic [5:0] ic_kind;
  mode_e      ic_mode;

  logic       kw_hit;
  logic [4:0] kw_idx;
  stu_res_t   word_res;
  logic       word_end, eol;
  logic [8:0] esc;

  stu_res_t   pre0, pre1;
  logic [1:0] pre_n;
  logic       do_idle, put_en;
  logic [7:0] put_val;
  stu_entry_t ent;

  assign c          = in_data_i.ch;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cur_line   = (line_q == LineMax) ? LineMax : line_q + 1'b1;
  assign eol        = (c == ChLf) || (c == ChNul);
  assign esc        = esc_map(c);

  assign word_end = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf) ||
                    (c == ChLParen) || (c == ChLBrace) || (c == ChRBrace) ||
                    (c == ChRParen) || (c == ChComma) || (c == ChSemi) ||
                    (c == ChBang) || (c == ChNul);

  always_comb begin
    ic_has      = 1'b1;
    ic_kind     = KindNewline;
    ic_mode     = ModeIdle;
    ic_line_inc = 1'b0;
    ic_word     = 1'b0;
    ic_str      = 1'b0;
    unique case (c)
      ChSpace, ChTab, ChCr: ic_has = 1'b0;
      ChLf:                 ic_line_inc = 1'b1;
      ChNul, ChHash:        ic_mode = ModeComment;
      ChSemi:               ic_kind = KindNewline;
      ChBang:               ic_kind = KindBang;
      ChLParen:             ic_kind = KindLParen;
      ChRParen:             ic_kind = KindRParen;
      ChLBrace:             ic_kind = KindLBrace;
      ChRBrace:             ic_kind = KindRBrace;
      ChComma:              ic_kind = KindErr;
      ChQuote: begin
        ic_has  = 1'b0;
        ic_mode = ModeStr;
        ic_str  = 1'b1;
      end
      default: begin
        ic_has  = 1'b0;
        ic_mode = ModeWord;
        ic_word = 1'b1;
      end
    endcase
  end

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = 0; i < NumKw; i++) begin
      if (wvec_q == KwText[i]) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  always_comb begin
    word_res.value = ErrUnknownWord;
    word_res.kind  = KindErr;
    if (wlen_q >= 8'(TokenBuf)) begin
      word_res.value = ErrWordLong;
    end else if (wlen_q <= 8'(KwChars) && kw_hit) begin
      word_res.kind = KindKw0 + {1'b0, kw_idx};
    end
  end

  always_comb begin
    mode_d  = mode_q;
    wvec_d  = wvec_q;
    wlen_d  = wlen_q;
    slen_d  = slen_q;
    line_d  = line_q;
    pre0    = '0;
    pre1    = '0;
    pre_n   = 2'd0;
    do_idle = 1'b0;
    put_en  = 1'b0;
    put_val = c;

    if (in_data_i.end_of_input) begin
      pre0.kind = KindEof;
      pre_n     = 2'd1;
      mode_d    = ModeIdle;
      wlen_d    = '0;
      slen_d    = '0;
    end else begin
      unique case (mode_q)
        ModeWord: begin
          if (word_end) begin
            pre0    = word_res;
            pre_n   = 2'd1;
            do_idle = 1'b1;
          end else begin
            if (wlen_q < 8'(KwChars)) wvec_d = {wvec_q[KwChars*8-9:0], c};
            if (wlen_q < 8'(TokenBuf)) wlen_d = wlen_q + 8'd1;
          end
        end
        ModeStr: begin
          if (c == ChQuote) begin
            pre0.kind = KindStrEnd;
            pre_n     = 2'd1;
            mode_d    = ModeIdle;
          end else if (eol) begin
            pre0.kind  = KindErr;
            pre0.value = ErrNoQuote;
            pre1.kind  = KindStrEnd;
            pre_n      = 2'd2;
            do_idle    = 1'b1;
          end else if (c == ChBackslash) begin
            mode_d = ModeStrEsc;
          end else begin
            put_en = 1'b1;
          end
        end
        ModeStrEsc: begin
          if (eol) begin
            pre0.kind  = KindErr;
            pre0.value = ErrEscAtEol;
            pre1.kind  = KindStrEnd;
            pre_n      = 2'd2;
            do_idle    = 1'b1;
          end else begin
            mode_d = ModeStr;
            if (esc[8]) begin
              put_en  = 1'b1;
              put_val = esc[7:0];
            end else begin
              pre0.kind  = KindErr;
              pre0.value = ErrBadEscape;
              pre_n      = 2'd1;
            end
          end
        end
        ModeSkip: begin
          if (c == ChQuote) begin
            pre0.kind = KindStrEnd;
            pre_n     = 2'd1;
            mode_d    = ModeIdle;
          end else if (eol) begin
            pre0.kind = KindStrEnd;
            pre_n     = 2'd1;
            do_idle   = 1'b1;
          end else if (c == ChBackslash) begin
            mode_d = ModeSkipEsc;
          end
        end
        ModeSkipEsc: begin
          if (eol) begin
            pre0.kind = KindStrEnd;
            pre_n     = 2'd1;
            do_idle   = 1'b1;
          end else begin
            mode_d = ModeSkip;
          end
        end
        ModeComment: begin
          if (c == ChLf) begin
            mode_d = ModeIdle;
            if (line_q != LineMax) line_d = line_q + 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (put_en) begin
        pre_n = 2'd1;
        if (slen_q >= 8'(TokenBuf - 1)) begin
          pre0.kind  = KindErr;
          pre0.value = ErrStrLong;
          mode_d     = ModeSkip;
        end else begin
          pre0.kind  = KindChar;
          pre0.value = put_val;
          slen_d     = slen_q + 8'd1;
        end
      end

      if (do_idle) begin
        mode_d = ic_mode;
        if (ic_line_inc && line_q != LineMax) line_d = line_q + 1'b1;
        if (ic_word) begin
          wvec_d = {{(KwChars*8-8){1'b0}}, c};
          wlen_d = 8'd1;
        end
        if (ic_str) slen_d = '0;
      end
    end
  end

  always_comb begin
    ent        = '0;
    ent.line   = in_data_i.end_of_input ? line_q : cur_line;
    ent.res[0] = pre0;
    ent.res[1] = pre1;
    ent.cnt    = pre_n;
    if (do_idle && ic_has) begin
      ent.res[pre_n].kind  = ic_kind;
      ent.res[pre_n].value = '0;
      ent.cnt              = pre_n + 2'd1;
    end
  end

  assign q_push_o = accept && (ent.cnt != 2'd0);
  assign q_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      wlen_q <= '0;
      slen_q <= '0;
      line_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      wlen_q <= wlen_d;
      slen_q <= slen_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wvec_q <= wvec_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stu_queue.sv
// ----------------------------------------------------------------------------
// stu_queue
// Short FIFO of token groups between the lexer and the output serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_queue
  import stu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire stu_entry_t  push_data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output stu_entry_t       head_o
);

  stu_entry_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]      count_q;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && !empty_o) rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/stu_back.sv
// ----------------------------------------------------------------------------
// stu_back
// Output serializer: while not stalled, walks the queue head's tokens one per
// cycle into the output register and marks the last token of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_back
  import stu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  wire stu_entry_t  q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output stu_out_t         out_data_o
);

  logic       out_valid_q;
  stu_out_t   out_q;
  logic [1:0] idx_q;
  logic       load, is_last;

  assign load    = (!out_valid_q || out_ready_i) && !q_empty_i;
  assign is_last = (idx_q == q_head_i.cnt - 2'd1);
  assign q_pop_o = load && is_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.kind        <= q_head_i.res[idx_q].kind;
      out_q.value       <= q_head_i.res[idx_q].value;
      out_q.line_number <= q_head_i.line;
      out_q.last        <= is_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/script_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// script_tokenizer_unit
// Streaming script lexer: one char in, one token out per cycle unless stalled.
// ----------------------------------------------------------------------------
// Path: tokens pass the queue memory and then the output register.
// Throughput: one character per cycle while each gives at most one token and
//   out_ready_i is high; the output register drains one token per cycle while
//   out_ready_i is high; a 4-group queue decouples, and stalls input when full.
// Reset: lexer between tokens, line count zero, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module script_tokenizer_unit
  import stu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire stu_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output stu_out_t      out_data_o
);

  logic       q_push, q_full, q_pop, q_empty;
  stu_entry_t q_wdata, q_head;

  stu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  stu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  stu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
